>>> sv/htad_pkg.sv
// Shared types and constants for the age/depth replacement hash table.
// Used by the front, back and top level modules; no dependencies.
package htad_pkg;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_PROBE = 2'd1;
    localparam logic [1:0] ACT_AGE   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [0:0] REG_ENTRIES = 1'd0;
    localparam logic [0:0] REG_MATE    = 1'd1;

    // Classified command passed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] hash;
        logic [7:0]  ply;
        logic [7:0]  depth;
        logic [1:0]  bound_flag;
        logic [15:0] score;
        logic [15:0] move_id;
    } t_cmd;

    typedef struct packed {
        logic        hit;
        logic [7:0]  depth;
        logic [1:0]  flag;
        logic [15:0] score;
        logic [15:0] move;
    } t_res;

endpackage

>>> sv/htad_front.sv
// Front part: input queue of two commands feeding the back part.
// Depends on htad_pkg.
module htad_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  htad_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output htad_pkg::t_cmd o_cmd,
    input  logic           i_take
);
    htad_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w, t;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w = i_push && !o_full;
    assign t = i_take && o_valid;

    // store incoming commands
    always_ff @(posedge i_clk) begin
        if (w) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w) r_wp <= ~r_wp;
            if (t) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w} - {1'b0, t};
        end
    end
endmodule

>>> sv/htad_back.sv
// Back part: index multiply, table read, replace decision, write, result.
// Depends on htad_pkg.
module htad_back #(
    parameter int DEPTH = 65536,
    parameter int AGES  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [16:0]    i_cfg_data,
    input  logic           i_valid,
    input  htad_pkg::t_cmd i_cmd,
    output logic           o_take,
    output logic           o_empty,
    output htad_pkg::t_res o_res,
    input  logic           i_pop
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = AW + 1;
    localparam logic [NW-1:0] NMAX = NW'(DEPTH);
    localparam logic [4:0] AGE_LAST = 5'(AGES - 1);

    localparam logic [2:0] S_IDLE = 3'd0, S_MUL1 = 3'd1, S_MUL2 = 3'd2,
                           S_READ = 3'd3, S_EXEC = 3'd4, S_WIPE = 3'd5;

    // entry: key, depth, flag, age, score, move
    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  depth;
        logic [1:0]  flag;
        logic [4:0]  age;
        logic [15:0] score;
        logic [15:0] move;
    } t_ent;

    t_ent r_mem [DEPTH];
    t_ent r_rd;
    htad_pkg::t_cmd r_cmd;
    logic [2:0]  r_st;
    logic [16:0] r_entries;
    logic [14:0] r_thr;
    logic [4:0]  r_age;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_idx, r_wipe;
    logic [32+NW-1:0] r_plo, r_phi;
    logic        r_ovalid;
    htad_pkg::t_res r_res;

    logic [32+NW:0] sum;
    logic [AW:0] idx_full;
    logic        take;
    logic signed [16:0] sc, thr_s;
    logic [15:0] n_score, n_move;
    logic        do_write;
    t_ent        n_ent;

    // clamp entries to 1..DEPTH
    always_comb begin
        if (r_entries == 17'd0) r_n = NW'(1);
        else if (32'(r_entries) > 32'(DEPTH)) r_n = NMAX;
        else r_n = NW'(r_entries);
    end

    assign sum = {1'b0, r_phi} + (33+NW)'(r_plo >> 32);
    assign idx_full = (AW+1)'(sum >> 32);

    // replacement decision and mate adjustment
    always_comb begin
        take = (r_rd.key == 64'd0) || (r_rd.age != r_age) ||
               (r_rd.depth <= r_cmd.depth);
        sc = 17'(signed'(r_cmd.score));
        thr_s = {2'b00, r_thr};
        if (sc < -thr_s) n_score = r_cmd.score - {8'd0, r_cmd.ply};
        else if (sc > thr_s) n_score = r_cmd.score + {8'd0, r_cmd.ply};
        else n_score = r_cmd.score;
        n_move = (r_cmd.move_id == 16'd0 && r_rd.key == r_cmd.hash) ?
                 r_rd.move : r_cmd.move_id;
        n_ent = '{key: r_cmd.hash, depth: r_cmd.depth, flag: r_cmd.bound_flag,
                  age: r_age, score: n_score, move: n_move};
        do_write = (r_st == S_EXEC) && (r_cmd.action == htad_pkg::ACT_STORE) && take;
    end

    assign o_take = (r_st == S_IDLE) && !r_ovalid && !i_cfg_we;
    assign o_empty = !r_ovalid;
    assign o_res = r_res;

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_st == S_WIPE) r_mem[r_wipe] <= '0;
        else if (do_write) r_mem[r_idx] <= n_ent;
        r_rd <= r_mem[r_idx];
    end

    // payload registers; clear the result on every transfer in
    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_cmd <= i_cmd;
            r_res <= '0;
        end
        if (r_st == S_MUL1) begin
            r_phi <= (32+NW)'(r_cmd.hash[63:32] * r_n);
            r_plo <= (32+NW)'(r_cmd.hash[31:0] * r_n);
        end
        if (r_st == S_MUL2)
            r_idx <= (idx_full >= (AW+1)'(DEPTH)) ? AW'(DEPTH - 1) : AW'(idx_full);
        if (r_st == S_EXEC) begin
            r_res <= '0;
            if (r_cmd.action == htad_pkg::ACT_PROBE && r_rd.key == r_cmd.hash)
                r_res <= '{hit: 1'b1, depth: r_rd.depth, flag: r_rd.flag,
                           score: r_rd.score, move: r_rd.move};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_WIPE;
            r_wipe <= '0;
            r_age <= '0;
            r_entries <= 17'd65536;
            r_thr <= 15'd32000;
            r_ovalid <= 1'b0;
        end else begin
            if (i_pop && r_ovalid) r_ovalid <= 1'b0;
            if (i_cfg_we && i_cfg_idx == htad_pkg::REG_MATE) r_thr <= i_cfg_data[14:0];
            if (i_cfg_we && i_cfg_idx == htad_pkg::REG_ENTRIES) begin
                r_entries <= i_cfg_data;
                r_age <= '0;
                r_wipe <= '0;
                r_st <= S_WIPE;
            end else begin
                case (r_st)
                    S_IDLE: if (o_take && i_valid) begin
                        if (i_cmd.action == htad_pkg::ACT_STORE ||
                            i_cmd.action == htad_pkg::ACT_PROBE) begin
                            r_st <= S_MUL1;
                        end else begin
                            r_ovalid <= 1'b1;
                            if (i_cmd.action == htad_pkg::ACT_AGE) begin
                                r_age <= (r_age == AGE_LAST) ? 5'd0 : r_age + 5'd1;
                            end else begin
                                r_age <= '0;
                                r_wipe <= '0;
                                r_st <= S_WIPE;
                            end
                        end
                    end
                    S_MUL1: r_st <= S_MUL2;
                    S_MUL2: r_st <= S_READ;
                    S_READ: r_st <= S_EXEC;
                    S_EXEC: begin
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                    S_WIPE: begin
                        r_wipe <= r_wipe + 1'b1;
                        if (r_wipe == AW'(DEPTH - 1)) r_st <= S_IDLE;
                    end
                    default: r_st <= S_IDLE;
                endcase
            end
        end
    end
endmodule

>>> sv/hash_table_with_age_depth_replace_core.sv
// Top level of the age/depth replacement hash table.
// Depends on htad_pkg, htad_front and htad_back.
//
// A store or probe passes through the back sequencer states MUL1 and MUL2 (the
// 32x17 index multiply), READ (the registered table read) and EXEC (decide and
// write), after passing through the two-entry input queue; new-search items
// are finished in IDLE. A clear, a write of entries_in_use and reset start a
// clearing pass over all TABLE_DEPTH entries, one entry a cycle, during which
// no item is started. The result of a clear is delivered when the pass begins.
module hash_table_with_age_depth_replace_core #(
    parameter int TABLE_DEPTH = 65536,
    parameter int AGE_CYCLE   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_hash,
    input  logic [7:0]  i_ply,
    input  logic [7:0]  i_depth,
    input  logic [1:0]  i_bound_flag,
    input  logic signed [15:0] i_score,
    input  logic [15:0] i_move_id,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit,
    output logic [7:0]  o_hit_depth,
    output logic [1:0]  o_hit_flag,
    output logic signed [15:0] o_hit_score,
    output logic [15:0] o_hit_move
);
    htad_pkg::t_cmd in_cmd, q_cmd;
    htad_pkg::t_res res;
    logic q_valid, q_take;

    assign in_cmd = '{action: i_action, hash: i_hash, ply: i_ply, depth: i_depth,
                      bound_flag: i_bound_flag, score: i_score, move_id: i_move_id};

    htad_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(in_cmd), .o_full(full),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    htad_back #(.DEPTH(TABLE_DEPTH), .AGES(AGE_CYCLE)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(q_valid), .i_cmd(q_cmd), .o_take(q_take),
        .o_empty(empty), .o_res(res), .i_pop(pop)
    );

    assign o_hit = res.hit;
    assign o_hit_depth = res.depth;
    assign o_hit_flag = res.flag;
    assign o_hit_score = res.score;
    assign o_hit_move = res.move;
endmodule
